/* rtl/rmq_pkg.sv */
// shared types and constants for the rotation matrix to quaternion block
`default_nettype none

package rmq_pkg;

  // default fraction bits of every matrix entry and quaternion component
  localparam int FRAC_DEF = 16;
  // width of one matrix entry or quaternion component
  localparam int FW = 18;
  // width of a sum or difference of two entries
  localparam int NW = FW + 1;
  // quotient bits resolved by the divider chain
  localparam int QB = FW + 1;

  // root width at the default fraction bits
  localparam int MW_DEF = (FRAC_DEF > FW) ? FRAC_DEF : FW;
  localparam int SQ_RTW_DEF = (MW_DEF + 2 + FRAC_DEF + 1) / 2;
  localparam int DV_DW_DEF = SQ_RTW_DEF + 1;

  // saturation limits
  localparam logic [FW-1:0] Q_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic [QB-1:0] Q_LIM = {2'b01, {(QB-2){1'b0}}};

  // component that takes the square root
  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_Z,
    SEL_W
  } sel_t;

  // side data riding along the square root chain
  typedef struct packed {
    sel_t                  sel;
    logic                  bad;
    logic [2:0]            neg;
    logic [2:0][NW-1:0]    mag;
  } sq_meta_t;

  // side data riding along the divider chain
  typedef struct packed {
    sel_t                  sel;
    logic                  bad;
    logic [2:0]            neg;
    logic [2:0]            ovf;
    logic [FW-1:0]         rq;
  } dv_meta_t;

endpackage

`default_nettype wire

/* rtl/rmq_sqrt_cell.sv */
// one step of the digit-by-digit square root: one root bit per cell
`default_nettype none

module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int RTW = SQ_RTW_DEF,
  parameter int AW  = $bits(sq_meta_t)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             vi,
  input  wire logic [2*RTW-1:0] rad_i,
  input  wire logic [RTW+1:0]   rem_i,
  input  wire logic [RTW-1:0]   root_i,
  input  wire logic [AW-1:0]    aux_i,
  output logic                  vo,
  output logic [2*RTW-1:0]      rad_o,
  output logic [RTW+1:0]        rem_o,
  output logic [RTW-1:0]        root_o,
  output logic [AW-1:0]         aux_o
);

  localparam int RMW = RTW + 2;
  localparam int TW  = RTW + 4;

  logic [TW-1:0] cur;
  logic [TW-1:0] trial;
  logic          fit;

  // bring in the next two radicand bits and try the next root bit
  always_comb begin
    cur   = {rem_i, rad_i[2*RTW-1 -: 2]};
    trial = TW'({root_i, 2'b01});
    fit   = cur >= trial;
  end

  // valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vi;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[2*RTW-3:0], 2'b00};
      rem_o  <= fit ? RMW'(cur - trial) : cur[RMW-1:0];
      root_o <= {root_i[RTW-2:0], fit};
      aux_o  <= aux_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/rmq_div_cell.sv */
// one restoring division step for three lanes sharing a divisor
`default_nettype none

module rmq_div_cell import rmq_pkg::*; #(
  parameter int DW = DV_DW_DEF,
  parameter int AW = $bits(dv_meta_t)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 vi,
  input  wire logic [DW-1:0]        den_i,
  input  wire logic [2:0][DW-1:0]   rem_i,
  input  wire logic [2:0][QB-1:0]   dvd_i,
  input  wire logic [2:0][QB-1:0]   q_i,
  input  wire logic [AW-1:0]        aux_i,
  output logic                      vo,
  output logic [DW-1:0]             den_o,
  output logic [2:0][DW-1:0]        rem_o,
  output logic [2:0][QB-1:0]        dvd_o,
  output logic [2:0][QB-1:0]        q_o,
  output logic [AW-1:0]             aux_o
);

  logic [2:0][DW:0]   t;
  logic [2:0]         fit;
  logic [2:0][DW-1:0] rem_next;

  // shift in one dividend bit per lane and subtract where it fits
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      t[l]        = {rem_i[l], dvd_i[l][QB-1]};
      fit[l]      = t[l] >= {1'b0, den_i};
      rem_next[l] = fit[l] ? DW'(t[l] - {1'b0, den_i}) : t[l][DW-1:0];
    end
  end

  // valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vi;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      den_o <= den_i;
      aux_o <= aux_i;
      for (int l = 0; l < 3; l++) begin
        rem_o[l] <= rem_next[l];
        dvd_o[l] <= {dvd_i[l][QB-2:0], 1'b0};
        q_o[l]   <= {q_i[l][QB-2:0], fit[l]};
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/rotation_matrix_to_quaternion.sv */
// rotation matrix to unit quaternion, pipelined square root and divider chains
//
//   channel  handshake            payload
//   in       in_valid/in_stall    m00 m01 m02 m10 m11 m12 m20 m21 m22
//   out      out_valid/out_stall  qx qy qz qw bad_input
//
// one matrix enters per cycle while in_stall is low; the square root cell chain is RTW
// cells long, where RTW = (max(FRAC_BITS,18) + FRAC_BITS + 3) / 2, and the divider
// chain adds 19 cells
// synchronous active-high reset clears all valid bits
// out_stall with a result waiting freezes the whole pipeline and raises in_stall
`default_nettype none

module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [FW-1:0] m00,
  input  wire logic signed [FW-1:0] m01,
  input  wire logic signed [FW-1:0] m02,
  input  wire logic signed [FW-1:0] m10,
  input  wire logic signed [FW-1:0] m11,
  input  wire logic signed [FW-1:0] m12,
  input  wire logic signed [FW-1:0] m20,
  input  wire logic signed [FW-1:0] m21,
  input  wire logic signed [FW-1:0] m22,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [FW-1:0]      qx,
  output logic signed [FW-1:0]      qy,
  output logic signed [FW-1:0]      qz,
  output logic signed [FW-1:0]      qw,
  output logic                      bad_input
);

  localparam int MW  = (FRAC_BITS > FW) ? FRAC_BITS : FW;
  localparam int RW  = MW + 3;
  localparam int VW  = MW + 2 + FRAC_BITS;
  localparam int RTW = (VW + 1) / 2;
  localparam int VE  = 2 * RTW;
  localparam int DW  = RTW + 1;
  localparam int SAW = $bits(sq_meta_t);
  localparam int DAW = $bits(dv_meta_t);
  localparam int CW  = FRAC_BITS + DW;
  localparam int XW  = NW + FRAC_BITS;
  localparam int PW  = RTW + FW;

  logic en;

  // whole pipeline moves unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------------------------------------------------------- decode
  logic signed [RW-1:0] e00, e11, e22, tr, rad, one, big;
  logic signed [NW-1:0] n0, n1, n2;
  logic [RW-2:0]        radu;
  logic [VE-1:0]        v0;
  sel_t                 sel;
  sq_meta_t             dec_meta;

  // pick the path, radicand and three numerators
  always_comb begin
    e00 = RW'(m00);
    e11 = RW'(m11);
    e22 = RW'(m22);
    one = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;
    tr  = e00 + e11 + e22;
    big = e00;
    sel = SEL_X;
    if (!tr[RW-1]) begin
      sel = SEL_W;
    end else begin
      if (e11 > big) begin
        sel = SEL_Y;
        big = e11;
      end
      if (e22 > big) begin
        sel = SEL_Z;
      end
    end
    unique case (sel)
      SEL_X: begin
        rad = one + e00 - e11 - e22;
        n0  = NW'(m10) + NW'(m01);
        n1  = NW'(m20) + NW'(m02);
        n2  = NW'(m21) - NW'(m12);
      end
      SEL_Y: begin
        rad = one + e11 - e22 - e00;
        n0  = NW'(m21) + NW'(m12);
        n1  = NW'(m01) + NW'(m10);
        n2  = NW'(m02) - NW'(m20);
      end
      SEL_Z: begin
        rad = one + e22 - e00 - e11;
        n0  = NW'(m02) + NW'(m20);
        n1  = NW'(m12) + NW'(m21);
        n2  = NW'(m10) - NW'(m01);
      end
      default: begin
        rad = tr + one;
        n0  = NW'(m21) - NW'(m12);
        n1  = NW'(m02) - NW'(m20);
        n2  = NW'(m10) - NW'(m01);
      end
    endcase
    dec_meta.sel    = sel;
    dec_meta.bad    = (sel != SEL_W) && (rad[RW-1] || (rad == '0));
    dec_meta.neg    = {n2[NW-1], n1[NW-1], n0[NW-1]};
    dec_meta.mag[0] = n0[NW-1] ? -n0 : n0;
    dec_meta.mag[1] = n1[NW-1] ? -n1 : n1;
    dec_meta.mag[2] = n2[NW-1] ? -n2 : n2;
    radu = dec_meta.bad ? '0 : rad[RW-2:0];
    v0   = VE'({radu, {FRAC_BITS{1'b0}}});
  end

  // decode register
  logic         s0_v;
  logic [VE-1:0] s0_rad;
  sq_meta_t     s0_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_rad  <= v0;
      s0_meta <= dec_meta;
    end
  end

  // ---------------------------------------------------------- square root
  logic [RTW:0]           sv;
  logic [RTW:0][VE-1:0]   srad;
  logic [RTW:0][RTW+1:0]  srem;
  logic [RTW:0][RTW-1:0]  sroot;
  logic [RTW:0][SAW-1:0]  saux;

  assign sv[0]    = s0_v;
  assign srad[0]  = s0_rad;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign saux[0]  = s0_meta;

  for (genvar k = 0; k < RTW; k++) begin : g_sq
    rmq_sqrt_cell #(
      .RTW (RTW),
      .AW  (SAW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vi     (sv[k]),
      .rad_i  (srad[k]),
      .rem_i  (srem[k]),
      .root_i (sroot[k]),
      .aux_i  (saux[k]),
      .vo     (sv[k+1]),
      .rad_o  (srad[k+1]),
      .rem_o  (srem[k+1]),
      .root_o (sroot[k+1]),
      .aux_o  (saux[k+1])
    );
  end

  // ------------------------------------------------------- divider setup
  sq_meta_t            sq_end;
  logic [RTW-1:0]      root;
  logic [PW-1:0]       rhw;
  logic [DW-1:0]       den;
  logic [2:0][XW-1:0]  dfull;
  logic [2:0][DW-1:0]  rem0;
  logic [2:0][QB-1:0]  dvd0;
  dv_meta_t            prep_meta;

  // divisor, root component and per-lane overflow check
  always_comb begin
    sq_end = sq_meta_t'(saux[RTW]);
    root   = sroot[RTW];
    den    = {root, 1'b0};
    rhw    = PW'(root >> 1);
    prep_meta.sel = sq_end.sel;
    prep_meta.bad = sq_end.bad;
    prep_meta.neg = sq_end.neg;
    prep_meta.rq  = (rhw > PW'(Q_MAX)) ? Q_MAX : rhw[FW-1:0];
    for (int l = 0; l < 3; l++) begin
      dfull[l]         = {sq_end.mag[l], {FRAC_BITS{1'b0}}};
      dvd0[l]          = dfull[l][QB-1:0];
      prep_meta.ovf[l] = CW'(dfull[l][XW-1:QB]) >= CW'(den);
      rem0[l]          = prep_meta.ovf[l] ? '0 : DW'(dfull[l][XW-1:QB]);
    end
  end

  // setup register
  logic                p_v;
  logic [DW-1:0]       p_den;
  logic [2:0][DW-1:0]  p_rem;
  logic [2:0][QB-1:0]  p_dvd;
  dv_meta_t            p_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= sv[RTW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_den  <= den;
      p_rem  <= rem0;
      p_dvd  <= dvd0;
      p_meta <= prep_meta;
    end
  end

  // -------------------------------------------------------------- divider
  logic [QB:0]                 dv;
  logic [QB:0][DW-1:0]         dden;
  logic [QB:0][2:0][DW-1:0]    drem;
  logic [QB:0][2:0][QB-1:0]    ddvd;
  logic [QB:0][2:0][QB-1:0]    dq;
  logic [QB:0][DAW-1:0]        daux;

  assign dv[0]   = p_v;
  assign dden[0] = p_den;
  assign drem[0] = p_rem;
  assign ddvd[0] = p_dvd;
  assign dq[0]   = '0;
  assign daux[0] = p_meta;

  for (genvar k = 0; k < QB; k++) begin : g_dv
    rmq_div_cell #(
      .DW (DW),
      .AW (DAW)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .vi    (dv[k]),
      .den_i (dden[k]),
      .rem_i (drem[k]),
      .dvd_i (ddvd[k]),
      .q_i   (dq[k]),
      .aux_i (daux[k]),
      .vo    (dv[k+1]),
      .den_o (dden[k+1]),
      .rem_o (drem[k+1]),
      .dvd_o (ddvd[k+1]),
      .q_o   (dq[k+1]),
      .aux_o (daux[k+1])
    );
  end

  // ---------------------------------------------------------------- finish
  dv_meta_t               dv_end;
  logic [2:0][QB-1:0]     qm;
  logic [2:0][QB-1:0]     qs;
  logic [2:0][FW-1:0]     lane;
  logic [FW-1:0]          fx, fy, fz, fw;

  // saturate, apply signs and route lanes to components
  always_comb begin
    dv_end = dv_meta_t'(daux[QB]);
    for (int l = 0; l < 3; l++) begin
      qm[l] = (dv_end.ovf[l] || (dq[QB][l] > Q_LIM)) ? Q_LIM : dq[QB][l];
      if (dv_end.neg[l]) begin
        qs[l] = -qm[l];
      end else begin
        qs[l] = (qm[l] > QB'(Q_MAX)) ? QB'(Q_MAX) : qm[l];
      end
      lane[l] = qs[l][FW-1:0];
    end
    unique case (dv_end.sel)
      SEL_X: begin
        fx = dv_end.rq;
        fy = lane[0];
        fz = lane[1];
        fw = lane[2];
      end
      SEL_Y: begin
        fy = dv_end.rq;
        fz = lane[0];
        fx = lane[1];
        fw = lane[2];
      end
      SEL_Z: begin
        fz = dv_end.rq;
        fx = lane[0];
        fy = lane[1];
        fw = lane[2];
      end
      default: begin
        fw = dv_end.rq;
        fx = lane[0];
        fy = lane[1];
        fz = lane[2];
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad_input <= dv_end.bad;
      qx        <= dv_end.bad ? '0 : fx;
      qy        <= dv_end.bad ? '0 : fy;
      qz        <= dv_end.bad ? '0 : fz;
      qw        <= dv_end.bad ? '0 : fw;
    end
  end

endmodule

`default_nettype wire

/* rtl/rmq_checker.sv */
// port checks for the rotation matrix to quaternion block, bound to the top level
`default_nettype none

module rmq_checker import rmq_pkg::*; (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire logic [FW-1:0] qx,
  input wire logic [FW-1:0] qy,
  input wire logic [FW-1:0] qz,
  input wire logic [FW-1:0] qw,
  input wire logic          bad_input
);

  // an invalid request gives an all-zero quaternion
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_input |-> qx == '0 && qy == '0 && qz == '0 && qw == '0)
    else $error("bad input with nonzero quaternion");

  // input side stalls only while a result is held at the output
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(qx) && $stable(qy)
      && $stable(qz) && $stable(qw) && $stable(bad_input))
    else $error("stalled result changed");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);

`default_nettype wire

/* dv/tb_rotation_matrix_to_quaternion.sv */
// testbench for the rotation matrix to quaternion block
`default_nettype none

module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int FRAC = FRAC_DEF;
  localparam int N_RAND = 550;
  localparam int TAIL = 120;
  localparam int LIMIT = 400000;

  typedef logic signed [FW-1:0] ent_t;
  typedef struct packed {
    ent_t [8:0] m;
  } mat_t;
  typedef struct packed {
    ent_t x, y, z, w;
    logic bad;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, bad_input;
  ent_t m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0, m12 = '0;
  ent_t m20 = '0, m21 = '0, m22 = '0;
  ent_t qx, qy, qz, qw;

  mat_t pending_mats[$];
  quat_t expected_quats[$];
  bit calm = 1'b0;
  bit stim_done = 1'b0;
  int errors = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_gap = 0;

  rotation_matrix_to_quaternion u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22), .out_valid(out_valid), .out_stall(out_stall),
    .qx(qx), .qy(qy), .qz(qz), .qw(qw), .bad_input(bad_input)
  );

  always #10 clk = ~clk;

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic ent_t clamp18(longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return -18'sd131072;
    return ent_t'(v);
  endfunction

  // scaled quotient truncated toward zero, saturated
  function automatic ent_t frac_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    if (den == 0) return '0;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag << FRAC) / den;
    if (q > 131072) q = 131072;
    return clamp18((num < 0) ? -longint'(q) : longint'(q));
  endfunction

  // quaternion predicted from one matrix
  function automatic quat_t predict_quat(mat_t a);
    longint m[3][3];
    longint q[4];
    longint tr, rad;
    longint unsigned root, den;
    int i1, i2, i3;
    quat_t r;
    for (int k = 0; k < 9; k++) m[k / 3][k % 3] = longint'(a.m[k]);
    q = '{0, 0, 0, 0};
    r.bad = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr >= 0) begin
      root = int_sqrt(longint'(tr + (64'sd1 << FRAC)) << FRAC);
      den = root << 1;
      q[3] = clamp18(longint'(root >> 1));
      q[0] = frac_div(m[2][1] - m[1][2], den);
      q[1] = frac_div(m[0][2] - m[2][0], den);
      q[2] = frac_div(m[1][0] - m[0][1], den);
    end else begin
      i1 = 0;
      if (m[1][1] > m[i1][i1]) i1 = 1;
      if (m[2][2] > m[i1][i1]) i1 = 2;
      i2 = (i1 + 1) % 3;
      i3 = (i2 + 1) % 3;
      rad = (64'sd1 << FRAC) + m[i1][i1] - m[i2][i2] - m[i3][i3];
      if (rad <= 0) begin
        r.bad = 1'b1;
      end else begin
        root = int_sqrt(longint'(rad) << FRAC);
        den = root << 1;
        q[i1] = clamp18(longint'(root >> 1));
        q[i2] = frac_div(m[i2][i1] + m[i1][i2], den);
        q[i3] = frac_div(m[i3][i1] + m[i1][i3], den);
        q[3] = frac_div(m[i3][i2] - m[i2][i3], den);
      end
    end
    r.x = ent_t'(q[0]);
    r.y = ent_t'(q[1]);
    r.z = ent_t'(q[2]);
    r.w = ent_t'(q[3]);
    return r;
  endfunction

  function automatic ent_t rand_ent();
    case ($urandom_range(0, 5))
      0: return -18'sd131072;
      1: return 18'sd131071;
      2: return ent_t'($urandom_range(0, 65536));
      3: return -ent_t'($urandom_range(0, 65536));
      default: return ent_t'($urandom);
    endcase
  endfunction

  function automatic mat_t diag_mat(ent_t a, ent_t b, ent_t c, ent_t off);
    mat_t r;
    for (int k = 0; k < 9; k++) r.m[k] = off;
    r.m[0] = a;
    r.m[4] = b;
    r.m[8] = c;
    return r;
  endfunction

  // rotation-like matrix about a random axis with a small perturbation
  function automatic mat_t near_rotation();
    real ax, ay, az, n, th, c, s, t, e[9];
    mat_t r;
    ax = $urandom_range(0, 2000) - 1000.0;
    ay = $urandom_range(0, 2000) - 1000.0;
    az = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(ax * ax + ay * ay + az * az) + 1e-9;
    ax /= n; ay /= n; az /= n;
    th = $urandom_range(0, 6283) / 1000.0;
    c = $cos(th); s = $sin(th); t = 1.0 - c;
    e = '{t*ax*ax + c, t*ax*ay - s*az, t*ax*az + s*ay,
          t*ax*ay + s*az, t*ay*ay + c, t*ay*az - s*ax,
          t*ax*az - s*ay, t*ay*az + s*ax, t*az*az + c};
    for (int k = 0; k < 9; k++)
      r.m[k] = ent_t'($rtoi(e[k] * 65536.0) + $urandom_range(0, 8) - 4);
    return r;
  endfunction

  // stimulus: directed corners then random matrices
  initial begin
    mat_t a;
    pending_mats.push_back(diag_mat(18'sd65536, 18'sd65536, 18'sd65536, '0));
    pending_mats.push_back(diag_mat(18'sd65536, -18'sd65536, -18'sd65536, '0));
    pending_mats.push_back(diag_mat(-18'sd65536, 18'sd65536, -18'sd65536, '0));
    pending_mats.push_back(diag_mat(-18'sd65536, -18'sd65536, 18'sd65536, '0));
    pending_mats.push_back(diag_mat(-18'sd100, -18'sd100, -18'sd100, '0));
    pending_mats.push_back(diag_mat('0, '0, '0, '0));
    pending_mats.push_back(diag_mat(-18'sd131072, -18'sd131072, -18'sd131072, '0));
    pending_mats.push_back(diag_mat(18'sd131071, 18'sd131071, 18'sd131071, 18'sd131071));
    pending_mats.push_back(diag_mat(-18'sd131072, -18'sd131072, -18'sd131072,
                                    18'sd131071));
    pending_mats.push_back(diag_mat(-18'sd131072, -18'sd131072, -18'sd131072,
                                    -18'sd131072));
    pending_mats.push_back(diag_mat(-18'sd1, 18'sd131071, 18'sd131071, -18'sd131072));
    pending_mats.push_back(diag_mat(-18'sd131072, 18'sd131071, -18'sd131072, '0));
    pending_mats.push_back(diag_mat(18'sd131071, -18'sd131072, -18'sd131072, '0));
    // large off-diagonal differences
    a = diag_mat(-18'sd131072, -18'sd131072, 18'sd131071, '0);
    a.m[1] = 18'sd131071; a.m[3] = -18'sd131072;
    pending_mats.push_back(a);
    a = diag_mat(-18'sd32768, -18'sd32768, -18'sd32768, 18'sd131071);
    a.m[5] = -18'sd131072;
    pending_mats.push_back(a);
    for (int k = 0; k < 9; k++) a.m[k] = 18'sd131071;
    pending_mats.push_back(a);
    for (int k = 0; k < 9; k++) a.m[k] = -18'sd131072;
    pending_mats.push_back(a);
    for (int k = 0; k < 9; k++) a.m[k] = 18'sh2AAAA;
    pending_mats.push_back(a);
    for (int k = 0; k < 9; k++) a.m[k] = 18'sh15555;
    pending_mats.push_back(a);
    for (int i = 0; i < N_RAND; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        a = near_rotation();
      end else begin
        for (int k = 0; k < 9; k++) a.m[k] = rand_ent();
      end
      pending_mats.push_back(a);
    end
    stim_done = 1'b1;
  end

  // driver: present requests, hold while stalled
  always @(posedge clk) begin
    mat_t a;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 15) - 1;
        in_valid <= 1'b0;
      end else if (pending_mats.size() > 0) begin
        a = pending_mats.pop_front();
        expected_quats.push_back(predict_quat(a));
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
          {a.m[0], a.m[1], a.m[2], a.m[3], a.m[4], a.m[5], a.m[6], a.m[7], a.m[8]};
        in_valid <= 1'b1;
        if (pending_mats.size() < 100) calm = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= (out_gap > 1);
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(1, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    quat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: result with nothing expected: %h %h %h %h %b",
                 $time, qx, qy, qz, qw, bad_input);
        errors++;
      end else begin
        e = expected_quats.pop_front();
        if ({qx, qy, qz, qw, bad_input} !== {e.x, e.y, e.z, e.w, e.bad}) begin
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d bad=%b", $time,
                   e.x, e.y, e.z, e.w, e.bad);
          $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d bad=%b", $time,
                   qx, qy, qz, qw, bad_input);
          errors++;
        end
      end
    end
  end

  // reset, end of run and timeout
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        wait (stim_done && pending_mats.size() == 0);
        @(posedge clk);
        while (in_valid || expected_quats.size() > 0) @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (errors == 0 && expected_quats.size() == 0) begin
          $display("[rotation_matrix_to_quaternion] OK");
        end else begin
          $display("[rotation_matrix_to_quaternion] ERROR");
        end
        $finish;
      end
      begin
        while (cycles < LIMIT) begin
          @(posedge clk);
          cycles++;
        end
        $display("[rotation_matrix_to_quaternion] ERROR");
        $finish;
      end
    join
  end

endmodule

`default_nettype wire

/* rotation_matrix_to_quaternion.f */
rtl/rmq_pkg.sv
rtl/rmq_sqrt_cell.sv
rtl/rmq_div_cell.sv
rtl/rotation_matrix_to_quaternion.sv
rtl/rmq_checker.sv
dv/tb_rotation_matrix_to_quaternion.sv
